@@ rtl/core/q2e_pkg.sv @@
package q2e_pkg;

	localparam int SampleBitsDef   = 16;
	localparam int CordicStagesDef = 16;
	localparam int AngTabLen       = 24;
	// working width of CORDIC x/y: products at 2^46 = one, sums up to ~2^48, growth ~1.65
	localparam int CW = 52;

	typedef struct packed {
		logic signed [SampleBitsDef-1:0] q_w;
		logic signed [SampleBitsDef-1:0] q_x;
		logic signed [SampleBitsDef-1:0] q_y;
		logic signed [SampleBitsDef-1:0] q_z;
	} q2e_in_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               pitch_clamped;
	} q2e_out_t;

	// one CORDIC lane word
	typedef struct packed {
		logic                 act;   // still rotating (y not yet hit zero)
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          z;
	} q2e_lane_t;

	function automatic logic [31:0] ang_tab(input int i);
		logic [31:0] t [AngTabLen];
		t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
			32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
			32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
			32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
			32'd81};
		return t[i];
	endfunction

	// atan2 setup: quadrant fold, zero vector gives zero angle
	function automatic q2e_lane_t lane_init(input logic signed [CW-1:0] y,
		input logic signed [CW-1:0] x);
		q2e_lane_t l;
		l.act = 1'b1;
		l.x = x;
		l.y = y;
		l.z = '0;
		if (x < 0) begin
			l.x = -x;
			l.y = -y;
			l.z = 32'h8000_0000;
		end
		return l;
	endfunction

	function automatic logic [15:0] angle16(input logic [31:0] z);
		logic [31:0] t;
		t = z + 32'h8000;
		return t[31:16];
	endfunction

endpackage

@@ rtl/core/q2e_cordic_cell.sv @@
module q2e_cordic_cell
	import q2e_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  logic      clk,
	input  q2e_lane_t lane,
	output q2e_lane_t lane_s1
);

	localparam logic [31:0] Ang = ang_tab(STAGE);

	q2e_lane_t nxt;

	always_comb begin
		nxt = lane;
		if (lane.act) begin
			if (lane.y > 0) begin
				nxt.x = lane.x + (lane.y >>> STAGE);
				nxt.y = lane.y - (lane.x >>> STAGE);
				nxt.z = lane.z + Ang;
			end else if (lane.y < 0) begin
				nxt.x = lane.x - (lane.y >>> STAGE);
				nxt.y = lane.y + (lane.x >>> STAGE);
				nxt.z = lane.z - Ang;
			end else begin
				nxt.act = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= nxt;
	end

endmodule

@@ rtl/core/q2e_cordic_row.sv @@
module q2e_cordic_row
	import q2e_pkg::*;
#(
	parameter int CORDIC_STAGES = CordicStagesDef
) (
	input  logic      clk,
	input  q2e_lane_t lane_in,
	output q2e_lane_t lane_out
);

	localparam int N = (CORDIC_STAGES < AngTabLen) ? CORDIC_STAGES : AngTabLen;

	q2e_lane_t chain [N+1];

	assign chain[0] = lane_in;

	for (genvar i = 0; i < N; i++) begin : g_cell
		q2e_cordic_cell #(.STAGE(i)) u_cell (
			.clk    (clk),
			.lane   (chain[i]),
			.lane_s1(chain[i+1])
		);
	end

	assign lane_out = chain[N];

endmodule

@@ rtl/core/q2e_isqrt.sv @@
module q2e_isqrt
	import q2e_pkg::*;
(
	input  logic        clk,
	input  logic [60:0] n_in,     // 2^60 - s30^2
	input  logic [31:0] s_in,     // s30 carried alongside
	output logic [30:0] root,
	output logic [31:0] s_out
);

	// one result bit per cell, restoring method, 31 cells
	localparam int NB = 31;

	logic [61:0] rem_c [NB+1];
	logic [30:0] r_c   [NB+1];
	logic [31:0] s_c   [NB+1];

	assign rem_c[0] = {1'b0, n_in};
	assign r_c[0]   = '0;
	assign s_c[0]   = s_in;

	for (genvar i = 0; i < NB; i++) begin : g_cell
		localparam int B = NB - 1 - i;
		logic [61:0] trial;
		logic [61:0] rem_n;
		logic [30:0] r_n;
		always_comb begin
			trial = ({31'b0, r_c[i]} << (B + 1)) + (62'd1 << (2 * B));
			rem_n = rem_c[i];
			r_n   = r_c[i];
			if (rem_c[i] >= trial) begin
				rem_n = rem_c[i] - trial;
				r_n[B] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			rem_c[i+1] <= rem_n;
			r_c[i+1]   <= r_n;
			s_c[i+1]   <= s_c[i];
		end
	end

	assign root  = r_c[NB];
	assign s_out = s_c[NB];

endmodule

@@ rtl/core/quaternion_to_euler_angles.sv @@
// channel  | ports                   | handshake
// command  | start, busy, in_word    | taken when start && !busy
// result   | done, out_word          | done high one cycle, no back-pressure
// One word a cycle; busy is tied low. done rises when the word has passed the
// product stage, sum stage, 31 square-root cells, CORDIC cells and output
// register (CORDIC_STAGES capped at 24; roll and yaw are delayed to match the
// pitch path). Reset clears only the valid chain.
module quaternion_to_euler_angles
	import q2e_pkg::*;
#(
	parameter int CORDIC_STAGES = CordicStagesDef
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  q2e_in_t  in_word,
	output logic     done,
	output q2e_out_t out_word
);

	localparam int NC  = (CORDIC_STAGES < AngTabLen) ? CORDIC_STAGES : AngTabLen;
	localparam int LAT = 2 + 31 + NC + 1;
	localparam int SQD = 31;
	localparam int ShL = (SampleBitsDef <= 24) ? 24 - SampleBitsDef : 0;
	localparam int ShR = (SampleBitsDef > 24) ? SampleBitsDef - 24 : 0;

	assign busy = 1'b0;

	// rescale to Q1.23
	function automatic logic signed [23:0] to_q23(input logic signed [SampleBitsDef-1:0] v);
		logic signed [31:0] e;
		e = 32'(v);
		if (SampleBitsDef <= 24) return 24'(e <<< ShL);
		return 24'(e >>> ShR);
	endfunction

	logic signed [23:0] w, x, y, z;
	assign w = to_q23(in_word.q_w);
	assign x = to_q23(in_word.q_x);
	assign y = to_q23(in_word.q_y);
	assign z = to_q23(in_word.q_z);

	// stage 1: products
	logic signed [47:0] ww_s1, xx_s1, yy_s1, zz_s1, yz_s1, wx_s1, xy_s1, wz_s1, xz_s1, wy_s1;
	always_ff @(posedge clk) begin
		ww_s1 <= w * w; xx_s1 <= x * x; yy_s1 <= y * y; zz_s1 <= z * z;
		yz_s1 <= y * z; wx_s1 <= w * x; xy_s1 <= x * y; wz_s1 <= w * z;
		xz_s1 <= x * z; wy_s1 <= w * y;
	end

	// stage 2: sums, clamp, CORDIC setup
	logic signed [CW-1:0] ry, rx, yy2, yx, s;
	logic signed [CW-1:0] sc;
	logic                 clamp;
	logic signed [31:0]   s30;
	logic [63:0]          sq;
	always_comb begin
		ry  = 2 * (CW'(yz_s1) + CW'(wx_s1));
		rx  = CW'(ww_s1) - CW'(xx_s1) - CW'(yy_s1) + CW'(zz_s1);
		yy2 = 2 * (CW'(xy_s1) + CW'(wz_s1));
		yx  = CW'(ww_s1) + CW'(xx_s1) - CW'(yy_s1) - CW'(zz_s1);
		s   = 2 * (CW'(xz_s1) - CW'(wy_s1));
		sc  = s;
		clamp = 1'b0;
		if (s > (CW'(1) <<< 46)) begin
			sc = CW'(1) <<< 46; clamp = 1'b1;
		end else if (s < -(CW'(1) <<< 46)) begin
			sc = -(CW'(1) <<< 46); clamp = 1'b1;
		end
		s30 = 32'(sc >>> 16);
		sq  = 64'(s30 * s30);
	end

	q2e_lane_t roll_s2, yaw_s2;
	logic [60:0] n_s2;
	logic [31:0] s30_s2;
	logic        clamp_s2;
	always_ff @(posedge clk) begin
		roll_s2  <= lane_init(ry, rx);
		yaw_s2   <= lane_init(yy2, yx);
		n_s2     <= 61'((64'd1 << 60) - sq);
		s30_s2   <= s30;
		clamp_s2 <= clamp;
	end

	// pitch: square root then CORDIC
	logic [30:0] root;
	logic [31:0] s30_r;
	logic [31:0] s30_r_in;
	assign s30_r_in = s30_s2;
	q2e_isqrt u_sqrt (.clk(clk), .n_in(n_s2), .s_in(s30_r_in), .root(root), .s_out(s30_r));

	q2e_lane_t p_lane_in, p_lane_out, r_out, y_out;
	always_comb begin
		p_lane_in = lane_init(CW'($signed(s30_r)), CW'($signed({1'b0, root})));
		if (root == '0 && s30_r == '0) p_lane_in.act = 1'b0;
	end

	// roll/yaw delay line to match the square-root cells
	q2e_lane_t rd_q [SQD+1];
	q2e_lane_t yd_q [SQD+1];
	logic      cd_q [SQD+NC+1];
	assign rd_q[0] = roll_s2;
	assign yd_q[0] = yaw_s2;
	assign cd_q[0] = clamp_s2;
	for (genvar i = 0; i < SQD; i++) begin : g_dly
		always_ff @(posedge clk) begin
			rd_q[i+1] <= rd_q[i];
			yd_q[i+1] <= yd_q[i];
		end
	end
	for (genvar i = 0; i < SQD + NC; i++) begin : g_cdly
		always_ff @(posedge clk) cd_q[i+1] <= cd_q[i];
	end

	q2e_cordic_row #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll
		(.clk(clk), .lane_in(rd_q[SQD]), .lane_out(r_out));
	q2e_cordic_row #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw
		(.clk(clk), .lane_in(yd_q[SQD]), .lane_out(y_out));
	q2e_cordic_row #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch
		(.clk(clk), .lane_in(p_lane_in), .lane_out(p_lane_out));

	// zero vector: lane_init gives x=y=0, z=0; cells hold since y==0
	logic signed [32:0] pz;
	logic signed [16:0] pr;
	logic signed [15:0] pf;
	always_comb begin
		pz = 33'($signed(p_lane_out.z)) + 33'sd32768;
		pr = -17'(pz >>> 16);
		if (pr > 17'sd16384) pf = 16'sd16384;
		else if (pr < -17'sd16384) pf = -16'sd16384;
		else pf = pr[15:0];
	end

	// valid chain
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		out_word.roll          <= angle16(r_out.z);
		out_word.yaw           <= angle16(y_out.z);
		out_word.pitch         <= pf;
		out_word.pitch_clamped <= cd_q[SQD+NC];
	end
	assign done = vld_q[LAT-1];

	assert property (@(posedge clk) disable iff (!arst_n) busy == 1'b0)
		else $error("busy asserted");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_word.pitch <= 16'sd16384 && out_word.pitch >= -16'sd16384))
		else $error("pitch out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(out_word))
		else $error("unknown result word");

endmodule

@@ dv/quaternion_to_euler_angles_tb.sv @@
module quaternion_to_euler_angles_tb;
	import q2e_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Latency   = 3 + 31 + CordicStagesDef;
	localparam int WatchLimit = 4000;
	localparam int NumRandom = 500;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	q2e_in_t  in_word;
	logic     done;
	q2e_out_t out_word;

	q2e_out_t angles_due[$];
	int       fails;
	int       idle_cycles;
	bit       feeding_over;

	quaternion_to_euler_angles i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_word (in_word),
		.done    (done),
		.out_word(out_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint shr(input longint v, input int s);
		return v >>> s;
	endfunction

	// vectoring CORDIC, 2^31 = pi, wraps mod 2^32
	function automatic logic [31:0] vec_angle(input longint y, input longint x);
		logic [31:0] acc;
		longint xs;
		longint ys;
		acc = '0;
		if (x == 0 && y == 0) return '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < CordicStagesDef && i < AngTabLen; i++) begin
			xs = shr(x, i);
			ys = shr(y, i);
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + ang_tab(i);
			end else if (y < 0) begin
				x = x - ys;
				y = y + xs;
				acc = acc - ang_tab(i);
			end else begin
				break;
			end
		end
		return acc;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] round16(input logic [31:0] a);
		logic [31:0] t;
		t = a + 32'h8000;
		return t[31:16];
	endfunction

	function automatic q2e_out_t euler_of(input q2e_in_t q);
		q2e_out_t r;
		longint w, x, y, z, s, s30, p, one;
		logic [63:0] c;
		logic [31:0] za;
		w = longint'(q.q_w) <<< 8;
		x = longint'(q.q_x) <<< 8;
		y = longint'(q.q_y) <<< 8;
		z = longint'(q.q_z) <<< 8;
		one = 64'sd1 <<< 46;
		r.roll = round16(vec_angle(2 * (y * z + w * x), w * w - x * x - y * y + z * z));
		r.yaw  = round16(vec_angle(2 * (x * y + w * z), w * w + x * x - y * y - z * z));
		s = 2 * (x * z - w * y);
		r.pitch_clamped = 1'b0;
		if (s > one) begin
			s = one;
			r.pitch_clamped = 1'b1;
		end else if (s < -one) begin
			s = -one;
			r.pitch_clamped = 1'b1;
		end
		s30 = shr(s, 16);
		c = int_sqrt((64'd1 << 60) - 64'(s30 * s30));
		za = vec_angle(s30, longint'(c));
		p = longint'(signed'(za));
		p = -shr(p + 32768, 16);
		if (p > 16384) p = 16384;
		if (p < -16384) p = -16384;
		r.pitch = p[15:0];
		return r;
	endfunction

	typedef struct {
		q2e_in_t  q;
		bit       fixed;
		q2e_out_t want;
	} q_row_t;

	localparam logic signed [15:0] Pos = 16'sh7fff;
	localparam logic signed [15:0] Neg = -16'sh8000;
	localparam logic signed [15:0] Hlf = 16'sd23170;

	q_row_t rows[] = '{
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
		'{'{Pos, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
		'{'{16'sd0, Pos, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, Pos, 16'sd0}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, Pos}, 1'b0, '0},
		'{'{Neg, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{16'sd0, Neg, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 16'sd0, Neg}, 1'b0, '0},
		'{'{Hlf, 16'sd0, Hlf, 16'sd0}, 1'b0, '0},
		'{'{Hlf, 16'sd0, -Hlf, 16'sd0}, 1'b0, '0},
		'{'{Hlf, Hlf, 16'sd0, 16'sd0}, 1'b0, '0},
		'{'{Hlf, 16'sd0, 16'sd0, Hlf}, 1'b0, '0},
		'{'{Pos, Pos, Pos, Pos}, 1'b0, '0},
		'{'{Neg, Neg, Neg, Neg}, 1'b0, '0},
		'{'{Pos, Neg, Neg, Pos}, 1'b0, '0},
		'{'{Pos, Pos, Neg, Neg}, 1'b0, '0},
		'{'{Neg, Pos, Pos, Neg}, 1'b0, '0},
		'{'{16'sd1, -16'sd1, 16'sd1, -16'sd1}, 1'b0, '0},
		'{'{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0}
	};

	task automatic send_word(input q2e_in_t q, input bit fixed, input q2e_out_t want);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		in_word <= q;
		angles_due.push_back(fixed ? want : euler_of(q));
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return Pos;
			1: return Neg;
			default: return 16'($urandom());
		endcase
	endfunction

	// near-unit quaternion with random direction
	function automatic q2e_in_t rand_unit();
		q2e_in_t q;
		real a, b, c, d, n;
		a = real'($signed($urandom_range(0, 65535) - 32768));
		b = real'($signed($urandom_range(0, 65535) - 32768));
		c = real'($signed($urandom_range(0, 65535) - 32768));
		d = real'($signed($urandom_range(0, 65535) - 32768));
		n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
		q.q_w = 16'($rtoi(a / n * 32767.0));
		q.q_x = 16'($rtoi(b / n * 32767.0));
		q.q_y = 16'($rtoi(c / n * 32767.0));
		q.q_z = 16'($rtoi(d / n * 32767.0));
		return q;
	endfunction

	always @(posedge clk) begin
		q2e_out_t want;
		if (done) begin
			if (angles_due.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				want = angles_due.pop_front();
				if (out_word.roll !== want.roll) begin
					$error("roll: expected %0d, got %0d", want.roll, out_word.roll);
					fails++;
				end
				if (out_word.pitch !== want.pitch) begin
					$error("pitch: expected %0d, got %0d", want.pitch, out_word.pitch);
					fails++;
				end
				if (out_word.yaw !== want.yaw) begin
					$error("yaw: expected %0d, got %0d", want.yaw, out_word.yaw);
					fails++;
				end
				if (out_word.pitch_clamped !== want.pitch_clamped) begin
					$error("pitch_clamped: expected %0b, got %0b",
						want.pitch_clamped, out_word.pitch_clamped);
					fails++;
				end
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if (done || (start && !busy) || (feeding_over && angles_due.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		q2e_in_t q;
		fails = 0;
		idle_cycles = 0;
		feeding_over = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_word(rows[i].q, rows[i].fixed, rows[i].want);
		for (int n = 0; n < NumRandom; n++) begin
			if ($urandom_range(0, 3) == 0) begin
				q.q_w = rand_comp();
				q.q_x = rand_comp();
				q.q_y = rand_comp();
				q.q_z = rand_comp();
			end else begin
				q = rand_unit();
			end
			send_word(q, 1'b0, '0);
		end
		start <= 1'b0;
		feeding_over = 1'b1;
		while (angles_due.size() != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/q2e_pkg.sv
rtl/core/q2e_cordic_cell.sv
rtl/core/q2e_cordic_row.sv
rtl/core/q2e_isqrt.sv
rtl/core/quaternion_to_euler_angles.sv
dv/quaternion_to_euler_angles_tb.sv
